[rtl/msort_pkg.sv]
// Shared types for the merge sorter: element word and the sort engine status.
// No dependencies; compile first.
package msort_pkg;

  // One element, two's complement
  typedef logic signed [31:0] word_t;

  // Status of the merge engine as seen by the top level
  typedef struct packed {
    logic busy;     // engine is priming or merging
    logic done;     // one-cycle pulse: sorted run is complete
    logic src_sel;  // store holding the current run: 0 primary, 1 merge
  } msort_status_t;

endpackage

[rtl/msort_if.sv]
// Valid/ready channel interfaces for the merge sorter input and result streams.
// Depends on msort_pkg.
interface msort_in_if import msort_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface msort_out_if import msort_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t sorted_value;
  logic  last_out;
  logic  overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

[rtl/msort_ram.sv]
// Generic synchronous RAM: one write port, two read ports with registered read data.
// Read data holds while its read enable is low. No dependencies.
module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

[rtl/msort_merge.sv]
// Bottom-up merge engine: runs passes of width 1, 2, 4, ... between the two stores,
// one element written per cycle within a pass. Depends on msort_pkg; drives RAMs via the top.
module msort_merge import msort_pkg::*; #(
  parameter int MAX_ELEMENTS = 64,
  localparam int AW = $clog2(MAX_ELEMENTS),
  localparam int CW = $clog2(MAX_ELEMENTS + 1),
  localparam int WW = CW + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [CW-1:0] n_i,
  input  word_t         rdata_a_i,
  input  word_t         rdata_b_i,
  output logic [AW-1:0] raddr_a_o,
  output logic [AW-1:0] raddr_b_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output word_t         wdata_o,
  output msort_status_t status_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_MERGE = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] n_q, n_d;
  logic [WW-1:0] w_q, w_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, mid_q, mid_d, hi_q, hi_d, k_q, k_d;
  logic          src_sel_q, src_sel_d;
  logic          done_q, done_d;

  logic          a_ok, b_ok, take_a;
  logic [CW-1:0] i_nx, j_nx, k_nx;
  logic [WW-1:0] w2;
  logic [CW-1:0] blk_mid, blk_hi, pass_mid, pass_hi;

  // Clip a bound to the run length
  function automatic logic [CW-1:0] clip(input logic [WW-1:0] x, input logic [CW-1:0] n);
    clip = (x > WW'(n)) ? n : x[CW-1:0];
  endfunction

  // Pick the smaller head; ties go to the left half to keep the sort stable
  assign a_ok   = i_q < mid_q;
  assign b_ok   = j_q < hi_q;
  assign take_a = a_ok && (!b_ok || (rdata_a_i <= rdata_b_i));
  assign i_nx   = i_q + CW'(take_a);
  assign j_nx   = j_q + CW'(!take_a);
  assign k_nx   = k_q + CW'(1);

  // Bounds of the next block in this pass, and of the first block of the next pass
  assign w2       = w_q << 1;
  assign blk_mid  = clip(WW'(hi_q) + w_q, n_q);
  assign blk_hi   = clip(WW'(hi_q) + w2, n_q);
  assign pass_mid = clip(w2, n_q);
  assign pass_hi  = clip(w2 << 1, n_q);

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    w_d       = w_q;
    i_d       = i_q;
    j_d       = j_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    k_d       = k_q;
    src_sel_d = src_sel_q;
    done_d    = 1'b0;
    we_o      = 1'b0;
    wdata_o   = take_a ? rdata_a_i : rdata_b_i;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d       = n_i;
          src_sel_d = 1'b0;
          w_d       = WW'(1);
          i_d       = '0;
          mid_d     = clip(WW'(1), n_i);
          hi_d      = clip(WW'(2), n_i);
          j_d       = clip(WW'(1), n_i);
          k_d       = '0;
          // A single element is already sorted
          if (n_i < CW'(2)) begin
            done_d = 1'b1;
          end else begin
            state_d = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        state_d = S_MERGE;
      end
      S_MERGE: begin
        we_o = 1'b1;
        if (k_nx == hi_q) begin
          if (hi_q == n_q) begin
            // End of pass: swap stores, then finish or start the next width
            src_sel_d = !src_sel_q;
            if (w2 >= WW'(n_q)) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
            end else begin
              state_d = S_PRIME;
              w_d     = w2;
              i_d     = '0;
              mid_d   = pass_mid;
              hi_d    = pass_hi;
              j_d     = pass_mid;
              k_d     = '0;
            end
          end else begin
            // Advance to the next block pair without a bubble
            i_d   = hi_q;
            j_d   = blk_mid;
            mid_d = blk_mid;
            hi_d  = blk_hi;
            k_d   = k_nx;
          end
        end else begin
          i_d = i_nx;
          j_d = j_nx;
          k_d = k_nx;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Reads fetch the heads needed in the next cycle
  assign raddr_a_o = (state_q == S_MERGE) ? i_d[AW-1:0] : i_q[AW-1:0];
  assign raddr_b_o = (state_q == S_MERGE) ? j_d[AW-1:0] : j_q[AW-1:0];
  assign waddr_o   = k_q[AW-1:0];

  assign status_o.busy    = state_q != S_IDLE;
  assign status_o.done    = done_q;
  assign status_o.src_sel = src_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      src_sel_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      src_sel_q <= src_sel_d;
      done_q    <= done_d;
    end
  end

  // Pass bookkeeping
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    w_q   <= w_d;
    i_q   <= i_d;
    j_q   <= j_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    k_q   <= k_d;
  end

endmodule

[rtl/merge_sorter_top.sv]
// Merge sorter top level: loads a run, sorts it in two ping-pong RAMs, streams it out.
// Depends on msort_pkg, msort_if, msort_ram and msort_merge.
//
// With an always-ready sink, a run is loaded as its elements arrive, sorted in
// ceil(log2 n) merge passes that each prime the RAM reads and then write one element per
// cycle, marked finished by the engine's done pulse, and emitted through the read and
// output registers, a new read being issued as the pending one moves on. The merge engine
// writing one element per cycle into the single write port of the destination store sets
// the pace. Input is taken only while loading; the last result may still wait in the
// output register while the next run loads. Elements beyond MAX_ELEMENTS are dropped and
// every result of that run carries overflow.
module merge_sorter_top import msort_pkg::*; #(
  parameter int MAX_ELEMENTS = 64,
  localparam int AW = $clog2(MAX_ELEMENTS),
  localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  msort_in_if.sink           in_i,
  msort_out_if.source        out_o
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] e_q, e_d;
  logic          pend_q, pend_d;
  logic          pend_last_q;
  logic          out_v_q, out_v_d;
  word_t         out_data_q;
  logic          out_last_q, out_ovf_q;

  logic          in_acc, room, load_we, start;
  logic [CW-1:0] n_start;
  logic          move, issue, emit_end;

  msort_status_t m_st;
  logic [AW-1:0] m_raddr_a, m_raddr_b, m_waddr;
  logic          m_we;
  word_t         m_wdata;

  logic          prim_we, mrg_we, re_a;
  logic [AW-1:0] prim_waddr, raddr_a;
  word_t         prim_wdata;
  word_t         prim_rd_a, prim_rd_b, mrg_rd_a, mrg_rd_b, src_rd_a, src_rd_b;

  // Load side
  assign in_i.ready = state_q == ST_LOAD;
  assign in_acc     = in_i.valid && in_i.ready;
  assign room       = count_q < CW'(MAX_ELEMENTS);
  assign load_we    = in_acc && room;
  assign start      = in_acc && in_i.last;
  assign n_start    = room ? count_q + CW'(1) : count_q;

  // Emit side: one pending RAM read feeds the output register
  assign move     = pend_q && (!out_v_q || out_o.ready);
  assign issue    = (state_q == ST_EMIT) && (e_q < count_q) && (!pend_q || move);
  assign emit_end = (state_q == ST_EMIT) && (e_q == count_q) && (!pend_q || move);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    e_d     = e_q;
    unique case (state_q)
      ST_LOAD: begin
        if (load_we) begin
          count_d = count_q + CW'(1);
        end
        if (in_acc && !room) begin
          ovf_d = 1'b1;
        end
        if (start) begin
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        if (m_st.done) begin
          state_d = ST_EMIT;
          e_d     = '0;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          e_d = e_q + CW'(1);
        end
        if (emit_end) begin
          state_d = ST_LOAD;
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    if (issue) begin
      pend_d = 1'b1;
    end else if (move) begin
      pend_d = 1'b0;
    end
    out_v_d = out_v_q;
    if (move) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      e_q     <= '0;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      e_q     <= e_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
    end
  end

  // Tag the pending read and fill the output register
  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_last_q <= (e_q + CW'(1)) == count_q;
    end
    if (move) begin
      out_data_q <= src_rd_a;
      out_last_q <= pend_last_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.sorted_value = out_data_q;
  assign out_o.last_out     = out_last_q;
  assign out_o.overflow     = out_ovf_q;

  // Merge engine
  msort_merge #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .n_i      (n_start),
    .rdata_a_i(src_rd_a),
    .rdata_b_i(src_rd_b),
    .raddr_a_o(m_raddr_a),
    .raddr_b_o(m_raddr_b),
    .we_o     (m_we),
    .waddr_o  (m_waddr),
    .wdata_o  (m_wdata),
    .status_o (m_st)
  );

  // Store port steering: the engine writes the store that is not the source
  assign prim_we    = load_we || (m_we && m_st.src_sel);
  assign mrg_we     = m_we && !m_st.src_sel;
  assign prim_waddr = load_we ? count_q[AW-1:0] : m_waddr;
  assign prim_wdata = load_we ? in_i.value : m_wdata;
  assign raddr_a    = m_st.busy ? m_raddr_a : e_q[AW-1:0];
  assign re_a       = m_st.busy || issue;
  assign src_rd_a   = m_st.src_sel ? mrg_rd_a : prim_rd_a;
  assign src_rd_b   = m_st.src_sel ? mrg_rd_b : prim_rd_b;

  msort_ram #(
    .WIDTH($bits(word_t)),
    .DEPTH(MAX_ELEMENTS)
  ) u_primary (
    .clk_i    (clk_i),
    .we_i     (prim_we),
    .waddr_i  (prim_waddr),
    .wdata_i  (prim_wdata),
    .re_a_i   (re_a),
    .raddr_a_i(raddr_a),
    .rdata_a_o(prim_rd_a),
    .re_b_i   (m_st.busy),
    .raddr_b_i(m_raddr_b),
    .rdata_b_o(prim_rd_b)
  );

  msort_ram #(
    .WIDTH($bits(word_t)),
    .DEPTH(MAX_ELEMENTS)
  ) u_mergestore (
    .clk_i    (clk_i),
    .we_i     (mrg_we),
    .waddr_i  (m_waddr),
    .wdata_i  (m_wdata),
    .re_a_i   (re_a),
    .raddr_a_i(raddr_a),
    .rdata_a_o(mrg_rd_a),
    .re_b_i   (m_st.busy),
    .raddr_b_i(m_raddr_b),
    .rdata_b_o(mrg_rd_b)
  );

  // Checks
  a_load_engine_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !m_st.busy)
    else $error("input taken while the merge engine is running");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_done_in_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_st.done |-> state_q == ST_SORT)
    else $error("merge engine finished outside the sort phase");

  a_pend_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == ST_EMIT)
    else $error("read pending outside the emit phase");

endmodule

[bench/sort_checker.sv]
// Scoreboard for the merge sorter: watches both channels, predicts each run's sorted output.
// Depends on msort_pkg; instantiated by the testbench top beside the sorter.
module sort_checker import msort_pkg::*; #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_ready_i,
  input  word_t in_value_i,
  input  logic  in_last_i,
  input  logic  out_valid_i,
  input  logic  out_ready_i,
  input  word_t out_value_i,
  input  logic  out_last_i,
  input  logic  out_overflow_i,
  output int    fail_count_o,
  output int    pending_o,
  output int    results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t value;
    logic  last;
    logic  overflow;
  } sorted_elem_t;

  sorted_elem_t sorted_q[$];  // results still owed by the sorter, oldest first
  word_t        run_q[$];     // elements of the run being loaded
  logic         run_dropped;  // the current run lost elements to a full store
  int           fails;
  int           checked;
  sorted_elem_t want;

  // Sort the loaded run stably (equal elements keep arrival order) and queue its results
  function automatic void queue_sorted_run();
    word_t key;
    int    j;
    for (int i = 1; i < run_q.size(); i++) begin
      key = run_q[i];
      j = i - 1;
      while (j >= 0 && run_q[j] > key) begin
        run_q[j + 1] = run_q[j];
        j--;
      end
      run_q[j + 1] = key;
    end
    for (int i = 0; i < run_q.size(); i++) begin
      sorted_q.push_back('{value: run_q[i], last: (i == run_q.size() - 1),
                           overflow: run_dropped});
    end
    run_q.delete();
    run_dropped = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_q.delete();
      run_q.delete();
      run_dropped = 1'b0;
      fails = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      results_o <= 0;
    end else begin
      // Store the element while there is room, else mark the run as overflowing
      if (in_valid_i && in_ready_i) begin
        if (run_q.size() < MAX_ELEMENTS) begin
          run_q.push_back(in_value_i);
        end else begin
          run_dropped = 1'b1;
        end
        if (in_last_i) begin
          queue_sorted_run();
        end
      end

      // Compare each result transaction with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (sorted_q.size() == 0) begin
          $error("result with nothing expected: sorted_value %0d", out_value_i);
          fails++;
        end else begin
          want = sorted_q.pop_front();
          if (out_value_i !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, out_value_i);
            fails++;
          end
          if (out_last_i !== want.last) begin
            $error("last_out: expected %0b, got %0b", want.last, out_last_i);
            fails++;
          end
          if (out_overflow_i !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_overflow_i);
            fails++;
          end
        end
      end

      fail_count_o <= fails;
      pending_o <= sorted_q.size();
      results_o <= checked;
    end
  end

endmodule

[bench/testbench.sv]
// Top of the merge sorter bench: clock, reset, run stimulus, result back-pressure, verdict.
// Depends on msort_pkg, msort_if, merge_sorter_top and sort_checker.
module testbench import msort_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ELEMENTS = 64;
  localparam int STALL_LIMIT  = 4000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 64;

  logic  clk;
  logic  rst_n;
  logic  burst;          // no gaps on either side while set
  int    fail_count;
  int    pending;
  int    results;
  int    elems_sent;
  int    runs_sent;
  int    runs_dropped;
  int    idle_cycles;
  int    stall_left;
  word_t dir_q[$];

  msort_in_if  u_in ();
  msort_out_if u_out ();

  merge_sorter_top #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (u_in),
    .out_o  (u_out)
  );

  sort_checker #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (u_in.valid),
    .in_ready_i     (u_in.ready),
    .in_value_i     (u_in.value),
    .in_last_i      (u_in.last),
    .out_valid_i    (u_out.valid),
    .out_ready_i    (u_out.ready),
    .out_value_i    (u_out.sorted_value),
    .out_last_i     (u_out.last_out),
    .out_overflow_i (u_out.overflow),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix of extremes, small clustered values (many duplicates) and full-range words
  function automatic word_t rand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0:       return word_t'(32'h8000_0000);
        1:       return word_t'(32'h7fff_ffff);
        2:       return word_t'(0);
        default: return word_t'(-1);
      endcase
    end
    if (r < 40) return word_t'($urandom_range(0, 8)) - word_t'(4);
    return word_t'($urandom());
  endfunction

  function automatic int rand_len();
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 8);
    return $urandom_range(9, 40);
  endfunction

  // Offer one element after a random gap and hold it until taken
  task automatic send_elem(input word_t v, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      u_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    u_in.valid <= 1'b1;
    u_in.value <= v;
    u_in.last  <= lst;
    @(posedge clk);
    while (!u_in.ready) @(posedge clk);
    elems_sent++;
  endtask

  task automatic send_run(input int n);
    for (int i = 0; i < n; i++) begin
      send_elem(rand_word(), i == n - 1);
    end
    runs_sent++;
    if (n > MAX_ELEMENTS) runs_dropped++;
  endtask

  task automatic send_list();
    for (int i = 0; i < dir_q.size(); i++) begin
      send_elem(dir_q[i], i == dir_q.size() - 1);
    end
    runs_sent++;
  endtask

  task automatic send_phase(input int target);
    int start;
    start = elems_sent;
    while (elems_sent - start < target) send_run(rand_len());
  endtask

  // Hold the input idle until every predicted result has come back
  task automatic wait_drained();
    u_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result back-pressure: random stalls unless in a burst phase
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      u_out.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      u_out.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      u_out.ready <= 1'b1;
      if (!burst && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((u_in.valid && u_in.ready) || (u_out.valid && u_out.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    burst = 1'b0;
    elems_sent = 0;
    runs_sent = 0;
    runs_dropped = 0;
    idle_cycles = 0;
    u_in.valid <= 1'b0;
    u_in.value <= '0;
    u_in.last  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the word, with repeats
    dir_q = {word_t'(32'h7fff_ffff), word_t'(32'h8000_0000), word_t'(0), word_t'(-1),
             word_t'(1), word_t'(32'h8000_0000), word_t'(32'h7fff_ffff)};
    send_list();
    // Single-element run, then a two-element run already in signed order
    dir_q = {word_t'(32'h5555_5555)};
    send_list();
    dir_q = {word_t'(32'haaaa_aaaa), word_t'(32'h5555_5555)};
    send_list();
    // Mixed signs with duplicates
    dir_q = {word_t'(100), word_t'(7), word_t'(7), word_t'(-3), word_t'(0), word_t'(-3),
             word_t'(42), word_t'(-100)};
    send_list();
    wait_drained();

    // Random runs with idling on both sides
    send_phase(45);
    wait_drained();
    // Fill the store and overrun it; the closing element is itself dropped
    send_run(MAX_ELEMENTS + 2);
    // Back-to-back transactions with no gaps or stalls
    burst = 1'b1;
    send_phase(20);
    burst = 1'b0;
    send_phase(15);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d elements in %0d runs (%0d overran the store), %0d results checked",
             elems_sent, runs_sent, runs_dropped, results);
    $display("Summary: idle gaps and stalls on both channels plus one back-to-back phase");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/msort_pkg.sv
rtl/msort_if.sv
rtl/msort_ram.sv
rtl/msort_merge.sv
rtl/merge_sorter_top.sv
bench/sort_checker.sv
bench/testbench.sv
